@@ sv/wav_pcm16_stream_parser_macros.svh @@
// ----------------------------------------------------------------------------
// WAV PCM16 stream parser assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef WAV_PCM16_STREAM_PARSER_MACROS_SVH
`define WAV_PCM16_STREAM_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WPSP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WPSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/wpsp_pkg.sv @@
// ----------------------------------------------------------------------------
// WAV PCM16 stream parser package
// Types, tag constants and code points shared by the parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wpsp_pkg;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_CHUNK,
      PH_PAYLOAD,
      PH_PAD
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_HEADER = 2'd1,
      ST_BAD_FORMAT = 2'd2
   } status_type;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic [31:0] TAG_FMT        = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA       = 32'h6174_6164;
   localparam logic [31:0] MIN_FILE_BYTES = 32'd44;
   localparam logic [31:0] MIN_FMT_BYTES  = 32'd16;
   localparam logic [31:0] HEADER_LAST    = 32'd11;
   localparam logic [31:0] POS_MAX        = 32'hFFFF_FFFF;
   localparam logic [15:0] PCM_CODE       = 16'd1;
   localparam logic [15:0] PCM_BITS       = 16'd16;
   localparam logic [7:0]  INDEX_MAX      = 8'd255;

   // One queue entry: what a single accepted byte produces.
   typedef struct packed {
      logic               has_sample;
      logic signed [15:0] sample;
      logic [7:0]         chunk_number;
      logic               has_report;
      status_type         status;
      logic [15:0]        channel_count;
      logic [31:0]        rate_hz;
      logic [30:0]        sample_total;
      logic [7:0]         final_chunk;
   } entry_type;

   function automatic logic [7:0] riff_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'h52;
         2'd1:    val = 8'h49;
         2'd2:    val = 8'h46;
         default: val = 8'h46;
      endcase
      return val;
   endfunction

   function automatic logic [7:0] wave_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'h57;
         2'd1:    val = 8'h41;
         2'd2:    val = 8'h56;
         default: val = 8'h45;
      endcase
      return val;
   endfunction

endpackage

@@ sv/wpsp_front.sv @@
// ----------------------------------------------------------------------------
// WAV PCM16 stream parser front end
// Byte-level RIFF/WAVE walker; classifies each byte and builds queue entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpsp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          byte_value,
   input  logic                end_of_file,
   output logic                push,
   output wpsp_pkg::entry_type push_entry
);

   wpsp_pkg::phase_type phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [31:0] length_ff, length_in;
   logic [7:0]  low_ff, low_in;
   logic        hok_ff, hok_in;
   logic [15:0] pend_fmt_ff, pend_fmt_in;
   logic [15:0] pend_ch_ff, pend_ch_in;
   logic [31:0] pend_rate_ff, pend_rate_in;
   logic [15:0] pend_bits_ff, pend_bits_in;
   logic [15:0] com_fmt_ff, com_fmt_in;
   logic [15:0] com_ch_ff, com_ch_in;
   logic [31:0] com_rate_ff, com_rate_in;
   logic [15:0] com_bits_ff, com_bits_in;
   logic [31:0] com_size_ff, com_size_in;
   logic        seen_ff, seen_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  com_idx_ff, com_idx_in;

   logic [2:0]  k;
   logic [31:0] off;
   logic        off_odd;
   logic        hdr_done;
   logic [31:0] len_full;
   logic        head_end;
   logic        payload_end;
   logic        finish;
   logic [31:0] fin_len;

   // Shared decode of the current position within the chunk structure.
   always_comb begin
      k           = remaining_ff[2:0];
      off         = length_ff - remaining_ff;
      off_odd     = length_ff[0] ^ remaining_ff[0];
      hdr_done    = (pos_ff >= wpsp_pkg::HEADER_LAST);
      len_full    = {byte_value, length_ff[23:0]};
      head_end    = (phase_ff == wpsp_pkg::PH_CHUNK) && (k == 3'd7);
      payload_end = (phase_ff == wpsp_pkg::PH_PAYLOAD) && (remaining_ff == 32'd1);
      finish      = (head_end && (len_full == 32'd0)) || payload_end;
      fin_len     = head_end ? len_full : length_ff;
   end

   // Next parse phase.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         wpsp_pkg::PH_HEADER: begin
            if (hdr_done) phase_in = wpsp_pkg::PH_CHUNK;
         end
         wpsp_pkg::PH_CHUNK: begin
            if (head_end) begin
               if (finish) phase_in = fin_len[0] ? wpsp_pkg::PH_PAD : wpsp_pkg::PH_CHUNK;
               else        phase_in = wpsp_pkg::PH_PAYLOAD;
            end
         end
         wpsp_pkg::PH_PAYLOAD: begin
            if (finish) phase_in = fin_len[0] ? wpsp_pkg::PH_PAD : wpsp_pkg::PH_CHUNK;
         end
         wpsp_pkg::PH_PAD: begin
            phase_in = wpsp_pkg::PH_CHUNK;
         end
         default: begin
            phase_in = wpsp_pkg::PH_HEADER;
         end
      endcase
      if (end_of_file) phase_in = wpsp_pkg::PH_HEADER;
   end

   // Field updates and result building.
   always_comb begin
      pos_in       = pos_ff;
      tag_in       = tag_ff;
      remaining_in = remaining_ff;
      length_in    = length_ff;
      low_in       = low_ff;
      hok_in       = hok_ff;
      pend_fmt_in  = pend_fmt_ff;
      pend_ch_in   = pend_ch_ff;
      pend_rate_in = pend_rate_ff;
      pend_bits_in = pend_bits_ff;
      com_fmt_in   = com_fmt_ff;
      com_ch_in    = com_ch_ff;
      com_rate_in  = com_rate_ff;
      com_bits_in  = com_bits_ff;
      com_size_in  = com_size_ff;
      seen_in      = seen_ff;
      count_in     = count_ff;
      com_idx_in   = com_idx_ff;
      push_entry   = '0;

      case (phase_ff)
         wpsp_pkg::PH_HEADER: begin
            if (pos_ff < 32'd4 && byte_value != wpsp_pkg::riff_byte(pos_ff[1:0]))
               hok_in = 1'b0;
            if (pos_ff >= 32'd8 && pos_ff < 32'd12 &&
                byte_value != wpsp_pkg::wave_byte(pos_ff[1:0]))
               hok_in = 1'b0;
            if (hdr_done) remaining_in = '0;
         end
         wpsp_pkg::PH_CHUNK: begin
            // Fields fill from zero, so each byte simply lands in its lane.
            if (!k[2]) begin
               if (k == 3'd0) tag_in = '0;
               tag_in[8*k[1:0] +: 8] = byte_value;
            end else begin
               if (k == 3'd4) length_in = '0;
               length_in[8*k[1:0] +: 8] = byte_value;
            end
            if (head_end) begin
               if (tag_ff == wpsp_pkg::TAG_FMT) begin
                  pend_fmt_in  = '0;
                  pend_ch_in   = '0;
                  pend_rate_in = '0;
                  pend_bits_in = '0;
               end
               remaining_in = len_full;
            end else begin
               remaining_in = {29'd0, k} + 32'd1;
            end
         end
         wpsp_pkg::PH_PAYLOAD: begin
            if (tag_ff == wpsp_pkg::TAG_FMT) begin
               if (off < 32'd16) begin
                  case (off[3:0])
                     4'd0:  pend_fmt_in[7:0]   = byte_value;
                     4'd1:  pend_fmt_in[15:8]  = byte_value;
                     4'd2:  pend_ch_in[7:0]    = byte_value;
                     4'd3:  pend_ch_in[15:8]   = byte_value;
                     4'd4, 4'd5, 4'd6, 4'd7:
                        pend_rate_in[8*off[1:0] +: 8] = byte_value;
                     4'd14: pend_bits_in[7:0]  = byte_value;
                     4'd15: pend_bits_in[15:8] = byte_value;
                     default: ;
                  endcase
               end
            end else if (tag_ff == wpsp_pkg::TAG_DATA) begin
               if (!off_odd) begin
                  low_in = byte_value;
               end else if (hok_ff) begin
                  push_entry.has_sample   = 1'b1;
                  push_entry.sample       = {byte_value, low_ff};
                  push_entry.chunk_number = count_ff;
               end
            end
            remaining_in = remaining_ff - 32'd1;
         end
         default: begin
            remaining_in = '0;
         end
      endcase

      if (finish) begin
         if (tag_ff == wpsp_pkg::TAG_FMT && fin_len >= wpsp_pkg::MIN_FMT_BYTES) begin
            com_fmt_in  = pend_fmt_in;
            com_ch_in   = pend_ch_in;
            com_rate_in = pend_rate_in;
            com_bits_in = pend_bits_in;
         end else if (tag_ff == wpsp_pkg::TAG_DATA) begin
            com_size_in = fin_len;
            com_idx_in  = count_ff;
            seen_in     = 1'b1;
            if (count_ff != wpsp_pkg::INDEX_MAX) count_in = count_ff + 8'd1;
         end
         remaining_in = '0;
      end

      if (pos_ff != wpsp_pkg::POS_MAX) pos_in = pos_ff + 32'd1;

      if (end_of_file) begin
         push_entry.has_report = 1'b1;
         if (pos_ff < wpsp_pkg::MIN_FILE_BYTES - 32'd1 || !hok_in)
            push_entry.status = wpsp_pkg::ST_BAD_HEADER;
         else if (com_fmt_in != wpsp_pkg::PCM_CODE || com_ch_in == 16'd0 ||
                  com_rate_in == 32'd0 || com_bits_in != wpsp_pkg::PCM_BITS || !seen_in)
            push_entry.status = wpsp_pkg::ST_BAD_FORMAT;
         else
            push_entry.status = wpsp_pkg::ST_OK;
         if (push_entry.status == wpsp_pkg::ST_OK) begin
            push_entry.channel_count = com_ch_in;
            push_entry.rate_hz       = com_rate_in;
            push_entry.sample_total  = com_size_in[31:1];
            push_entry.final_chunk   = com_idx_in;
         end
         // The next byte starts a new file.
         pos_in       = '0;
         tag_in       = '0;
         remaining_in = '0;
         length_in    = '0;
         low_in       = '0;
         hok_in       = 1'b1;
         pend_fmt_in  = '0;
         pend_ch_in   = '0;
         pend_rate_in = '0;
         pend_bits_in = '0;
         com_fmt_in   = '0;
         com_ch_in    = '0;
         com_rate_in  = '0;
         com_bits_in  = '0;
         com_size_in  = '0;
         seen_in      = 1'b0;
         count_in     = '0;
         com_idx_in   = '0;
      end
   end

   assign push = accept && (push_entry.has_sample || push_entry.has_report);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= wpsp_pkg::PH_HEADER;
         pos_ff       <= '0;
         tag_ff       <= '0;
         remaining_ff <= '0;
         length_ff    <= '0;
         low_ff       <= '0;
         hok_ff       <= 1'b1;
         pend_fmt_ff  <= '0;
         pend_ch_ff   <= '0;
         pend_rate_ff <= '0;
         pend_bits_ff <= '0;
         com_fmt_ff   <= '0;
         com_ch_ff    <= '0;
         com_rate_ff  <= '0;
         com_bits_ff  <= '0;
         com_size_ff  <= '0;
         seen_ff      <= 1'b0;
         count_ff     <= '0;
         com_idx_ff   <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         tag_ff       <= tag_in;
         remaining_ff <= remaining_in;
         length_ff    <= length_in;
         low_ff       <= low_in;
         hok_ff       <= hok_in;
         pend_fmt_ff  <= pend_fmt_in;
         pend_ch_ff   <= pend_ch_in;
         pend_rate_ff <= pend_rate_in;
         pend_bits_ff <= pend_bits_in;
         com_fmt_ff   <= com_fmt_in;
         com_ch_ff    <= com_ch_in;
         com_rate_ff  <= com_rate_in;
         com_bits_ff  <= com_bits_in;
         com_size_ff  <= com_size_in;
         seen_ff      <= seen_in;
         count_ff     <= count_in;
         com_idx_ff   <= com_idx_in;
      end
   end

endmodule

@@ sv/wpsp_queue.sv @@
// ----------------------------------------------------------------------------
// WAV PCM16 stream parser entry queue
// Small register queue that decouples the byte walker from the result port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpsp_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  wpsp_pkg::entry_type push_entry,
   input  logic                pop,
   output wpsp_pkg::entry_type head,
   output logic                not_empty,
   output logic                full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   wpsp_pkg::entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign head      = slots_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (do_push && !do_pop)      count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

@@ sv/wpsp_back.sv @@
// ----------------------------------------------------------------------------
// WAV PCM16 stream parser back end
// Splits queue entries into result transfers and holds the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "wav_pcm16_stream_parser_macros.svh"

module wpsp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  wpsp_pkg::entry_type q_head,
   output logic                q_pop,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                rsp_kind,
   output logic signed [15:0]  rsp_sample,
   output logic [7:0]          rsp_chunk_number,
   output logic [1:0]          rsp_status,
   output logic [15:0]         rsp_channel_count,
   output logic [31:0]         rsp_rate_hz,
   output logic [30:0]         rsp_sample_total,
   output logic [7:0]          rsp_final_chunk,
   output logic                rsp_last
);

   logic               valid_ff, valid_in;
   logic               done_ff, done_in;
   logic               kind_ff, kind_in;
   logic signed [15:0] sample_ff, sample_in;
   logic [7:0]         chunk_ff, chunk_in;
   logic [1:0]         status_ff, status_in;
   logic [15:0]        chan_ff, chan_in;
   logic [31:0]        rate_ff, rate_in;
   logic [30:0]        total_ff, total_in;
   logic [7:0]         final_ff, final_in;
   logic               last_ff, last_in;
   logic               load;
   logic               emit_sample;

   assign load        = q_valid && (!valid_ff || rsp_ready);
   assign emit_sample = q_head.has_sample && !done_ff;

   always_comb begin
      valid_in  = valid_ff;
      done_in   = done_ff;
      kind_in   = kind_ff;
      sample_in = sample_ff;
      chunk_in  = chunk_ff;
      status_in = status_ff;
      chan_in   = chan_ff;
      rate_in   = rate_ff;
      total_in  = total_ff;
      final_in  = final_ff;
      last_in   = last_ff;
      q_pop     = 1'b0;
      if (rsp_ready) valid_in = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (emit_sample) begin
            kind_in   = wpsp_pkg::KIND_SAMPLE;
            sample_in = q_head.sample;
            chunk_in  = q_head.chunk_number;
            status_in = '0;
            chan_in   = '0;
            rate_in   = '0;
            total_in  = '0;
            final_in  = '0;
            last_in   = 1'b0;
            // A report riding on the same byte follows on the next transfer.
            done_in   = q_head.has_report;
            q_pop     = !q_head.has_report;
         end else begin
            kind_in   = wpsp_pkg::KIND_REPORT;
            sample_in = '0;
            chunk_in  = '0;
            status_in = q_head.status;
            chan_in   = q_head.channel_count;
            rate_in   = q_head.rate_hz;
            total_in  = q_head.sample_total;
            final_in  = q_head.final_chunk;
            last_in   = 1'b1;
            done_in   = 1'b0;
            q_pop     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      sample_ff <= sample_in;
      chunk_ff  <= chunk_in;
      status_ff <= status_in;
      chan_ff   <= chan_in;
      rate_ff   <= rate_in;
      total_ff  <= total_in;
      final_ff  <= final_in;
      last_ff   <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_sample        = sample_ff;
   assign rsp_chunk_number  = chunk_ff;
   assign rsp_status        = status_ff;
   assign rsp_channel_count = chan_ff;
   assign rsp_rate_hz       = rate_ff;
   assign rsp_sample_total  = total_ff;
   assign rsp_final_chunk   = final_ff;
   assign rsp_last          = last_ff;

   `WPSP_ASSERT_NOW(a_done_has_report, done_ff, q_valid && q_head.has_report, "split entry lost its report")
   `WPSP_ASSERT_NOW(a_entry_not_empty, q_valid, q_head.has_sample || q_head.has_report, "queue entry carries no result")
   `WPSP_ASSERT_NEXT(a_split_marked, load && emit_sample && q_head.has_report, done_ff, "sample with report not marked done")

endmodule

@@ sv/wav_pcm16_stream_parser.sv @@
// ----------------------------------------------------------------------------
// WAV PCM16 stream parser
// The block takes a RIFF/WAVE file one byte per req_ transfer (end_of_file
// marks the final byte) and accepts one byte every clock cycle while
// req_ready is high. With intact RIFF and WAVE tags, each data chunk yields
// a signed 16-bit sample on the rsp_ channel for every second payload byte,
// and the final byte yields a status report (kind 1, last 1), which follows
// the byte's sample when it has one. A byte walker decodes the chunk
// structure and writes what each byte produces into a queue of QUEUE_DEPTH
// entries; the output side drains that queue one result transfer per cycle
// while rsp_ready is high, so req_ready falls only when the queue is full,
// which happens when rsp_ready is held low. After the report the block is
// back in its reset state and the next byte starts a new file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wav_pcm16_stream_parser #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_byte_value,
   input  logic               req_end_of_file,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_kind,
   output logic signed [15:0] rsp_sample,
   output logic [7:0]         rsp_chunk_number,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_channel_count,
   output logic [31:0]        rsp_rate_hz,
   output logic [30:0]        rsp_sample_total,
   output logic [7:0]         rsp_final_chunk,
   output logic               rsp_last
);

   logic                accept;
   logic                push;
   wpsp_pkg::entry_type push_entry;
   logic                q_pop;
   wpsp_pkg::entry_type q_head;
   logic                q_valid;
   logic                q_full;

   // A byte is taken only when the queue has room for whatever it produces.
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   wpsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .byte_value  (req_byte_value),
      .end_of_file (req_end_of_file),
      .push        (push),
      .push_entry  (push_entry)
   );

   wpsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (q_head),
      .not_empty  (q_valid),
      .full       (q_full)
   );

   wpsp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_sample        (rsp_sample),
      .rsp_chunk_number  (rsp_chunk_number),
      .rsp_status        (rsp_status),
      .rsp_channel_count (rsp_channel_count),
      .rsp_rate_hz       (rsp_rate_hz),
      .rsp_sample_total  (rsp_sample_total),
      .rsp_final_chunk   (rsp_final_chunk),
      .rsp_last          (rsp_last)
   );

endmodule

@@ tb/tb_wav_pcm16_stream_parser.sv @@
// ----------------------------------------------------------------------------
// Testbench for the WAV PCM16 stream parser
// Whole RIFF/WAVE files go in one byte per transfer: a few hand-built files,
// one long file with many data chunks, most of them empty, and then random
// files. Some random files are well formed with random content. The rest are
// noise, broken tags, truncated files and damaged format chunks.
// A scoreboard class predicts every sample and status report. It checks each
// result transfer against the oldest prediction. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_wav_pcm16_stream_parser;

   // The header tags as little-endian words, so that byte n of a tag is
   // bits [8n+7:8n] of the word.
   localparam logic [31:0] RIFF_WORD = 32'h4646_4952;
   localparam logic [31:0] WAVE_WORD = 32'h4556_4157;

   // One result transfer, field for field as it appears on the rsp_ ports.
   typedef struct packed {
      logic                 kind;
      logic signed [15:0]   sample;
      logic [7:0]           chunk_number;
      wpsp_pkg::status_type status;
      logic [15:0]          channel_count;
      logic [31:0]          rate_hz;
      logic [30:0]          sample_total;
      logic [7:0]           final_chunk;
      logic                 last;
   } wave_result;

   // The scoreboard holds its own copy of the parser state. It turns every
   // accepted byte into the results that byte must cause, and it matches
   // result transfers against those results in order.
   class wave_scoreboard;
      logic [31:0]         byte_count;
      wpsp_pkg::phase_type phase;
      logic [31:0]         chunk_id;
      logic [31:0]         bytes_left;
      logic [31:0]         chunk_len;
      logic [7:0]          low_byte;
      logic                tags_ok;
      logic [15:0]         pend_code, pend_ch, pend_bits;
      logic [31:0]         pend_rate;
      logic [15:0]         use_code, use_ch, use_bits;
      logic [31:0]         use_rate;
      logic [31:0]         data_size;
      logic                data_seen;
      logic [7:0]          chunk_count;
      logic [7:0]          data_index;
      wave_result          expected_q[$];
      int                  failures;

      function new();
         clear_state();
         failures = 0;
      endfunction

      function void clear_state();
         byte_count  = '0;
         phase       = wpsp_pkg::PH_HEADER;
         chunk_id    = '0;
         bytes_left  = '0;
         chunk_len   = '0;
         low_byte    = '0;
         tags_ok     = 1'b1;
         pend_code   = '0;
         pend_ch     = '0;
         pend_bits   = '0;
         pend_rate   = '0;
         use_code    = '0;
         use_ch      = '0;
         use_bits    = '0;
         use_rate    = '0;
         data_size   = '0;
         data_seen   = 1'b0;
         chunk_count = '0;
         data_index  = '0;
      endfunction

      // Appends one prediction at the tail of the expected list.
      function void add_expected(input wave_result r);
         expected_q.insert(expected_q.size(), r);
      endfunction

      // A chunk payload has ended. A format chunk commits only when it was
      // long enough, and a data chunk commits its length and its index.
      function void close_payload();
         if (chunk_id == wpsp_pkg::TAG_FMT && chunk_len >= wpsp_pkg::MIN_FMT_BYTES) begin
            use_code = pend_code;
            use_ch   = pend_ch;
            use_rate = pend_rate;
            use_bits = pend_bits;
         end else if (chunk_id == wpsp_pkg::TAG_DATA) begin
            data_size  = chunk_len;
            data_index = chunk_count;
            data_seen  = 1'b1;
            if (chunk_count != wpsp_pkg::INDEX_MAX) begin
               chunk_count = chunk_count + 1;
            end
         end
         bytes_left = '0;
         phase      = chunk_len[0] ? wpsp_pkg::PH_PAD : wpsp_pkg::PH_CHUNK;
      endfunction

      function void note_byte(input logic [7:0] b, input logic eof);
         logic [31:0] pos;
         logic [31:0] off;
         logic [3:0]  step;
         logic [32:0] total;
         wave_result  r;
         pos = byte_count;
         case (phase)
            wpsp_pkg::PH_HEADER: begin
               if (pos < 4 && b != RIFF_WORD[8*pos[1:0] +: 8]) begin
                  tags_ok = 1'b0;
               end
               if (pos >= 8 && pos < 12 && b != WAVE_WORD[8*pos[1:0] +: 8]) begin
                  tags_ok = 1'b0;
               end
               if (pos >= wpsp_pkg::HEADER_LAST) begin
                  phase      = wpsp_pkg::PH_CHUNK;
                  bytes_left = '0;
               end
            end
            wpsp_pkg::PH_CHUNK: begin
               // Bytes 0..3 of a chunk header are the tag, 4..7 the length.
               step = {1'b0, bytes_left[2:0]};
               if (step == 0) chunk_id = '0;
               if (step == 4) chunk_len = '0;
               if (step < 4) begin
                  chunk_id = chunk_id | (32'(b) << (8*step));
               end else begin
                  chunk_len = chunk_len | (32'(b) << (8*(step - 4)));
               end
               step = step + 1;
               if (step == 8) begin
                  if (chunk_id == wpsp_pkg::TAG_FMT) begin
                     pend_code = '0;
                     pend_ch   = '0;
                     pend_rate = '0;
                     pend_bits = '0;
                  end
                  bytes_left = chunk_len;
                  phase      = wpsp_pkg::PH_PAYLOAD;
                  if (chunk_len == 0) close_payload();
               end else begin
                  bytes_left = 32'(step);
               end
            end
            wpsp_pkg::PH_PAYLOAD: begin
               off = chunk_len - bytes_left;
               if (chunk_id == wpsp_pkg::TAG_FMT) begin
                  case (off)
                     0:          pend_code = pend_code | 16'(b);
                     1:          pend_code = pend_code | {b, 8'h00};
                     2:          pend_ch   = pend_ch | 16'(b);
                     3:          pend_ch   = pend_ch | {b, 8'h00};
                     4, 5, 6, 7: pend_rate = pend_rate | (32'(b) << (8*(off - 4)));
                     14:         pend_bits = pend_bits | 16'(b);
                     15:         pend_bits = pend_bits | {b, 8'h00};
                     default:    ;
                  endcase
               end else if (chunk_id == wpsp_pkg::TAG_DATA) begin
                  if (!off[0]) begin
                     low_byte = b;
                  end else if (tags_ok) begin
                     r              = '0;
                     r.kind         = wpsp_pkg::KIND_SAMPLE;
                     r.sample       = {b, low_byte};
                     r.chunk_number = chunk_count;
                     add_expected(r);
                  end
               end
               bytes_left = bytes_left - 1;
               if (bytes_left == 0) close_payload();
            end
            default: begin
               phase      = wpsp_pkg::PH_CHUNK;
               bytes_left = '0;
            end
         endcase

         if (byte_count != wpsp_pkg::POS_MAX) byte_count = byte_count + 1;

         if (eof) begin
            total  = {1'b0, pos} + 33'd1;
            r      = '0;
            r.kind = wpsp_pkg::KIND_REPORT;
            r.last = 1'b1;
            if (total < wpsp_pkg::MIN_FILE_BYTES || !tags_ok) begin
               r.status = wpsp_pkg::ST_BAD_HEADER;
            end else if (use_code != wpsp_pkg::PCM_CODE || use_ch == 0 || use_rate == 0 ||
                         use_bits != wpsp_pkg::PCM_BITS || !data_seen) begin
               r.status = wpsp_pkg::ST_BAD_FORMAT;
            end else begin
               r.status        = wpsp_pkg::ST_OK;
               r.channel_count = use_ch;
               r.rate_hz       = use_rate;
               r.sample_total  = data_size[31:1];
               r.final_chunk   = data_index;
            end
            add_expected(r);
            clear_state();
         end
      endfunction

      function string describe(input wave_result r);
         return $sformatf({"kind=%0d sample=%0d chunk=%0d status=%0d channels=%0d ",
                           "rate=%0d total=%0d final=%0d last=%0d"},
                          r.kind, r.sample, r.chunk_number, r.status, r.channel_count,
                          r.rate_hz, r.sample_total, r.final_chunk, r.last);
      endfunction

      function void check_result(input wave_result got);
         wave_result want;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= 10) $display("result with nothing expected: %s", describe(got));
            return;
         end
         want = expected_q.pop_front();
         if (got.kind !== want.kind || got.sample !== want.sample ||
             got.chunk_number !== want.chunk_number || got.status !== want.status ||
             got.channel_count !== want.channel_count || got.rate_hz !== want.rate_hz ||
             got.sample_total !== want.sample_total ||
             got.final_chunk !== want.final_chunk || got.last !== want.last) begin
            failures++;
            if (failures <= 10) begin
               $display("result mismatch at %0t", $realtime);
               $display("   expected %s", describe(want));
               $display("   actual   %s", describe(got));
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_byte_value;
   logic               req_end_of_file;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_kind;
   logic signed [15:0] rsp_sample;
   logic [7:0]         rsp_chunk_number;
   logic [1:0]         rsp_status;
   logic [15:0]        rsp_channel_count;
   logic [31:0]        rsp_rate_hz;
   logic [30:0]        rsp_sample_total;
   logic [7:0]         rsp_final_chunk;
   logic               rsp_last;

   wave_scoreboard sb = new();

   // Bytes of the file that is about to be sent; the last one carries the
   // end-of-file mark.
   logic [7:0] file_bytes[$];

   // Idle state of each side: a run of transfers that either all wait a
   // random number of cycles or all go without waiting.
   int snd_run  = 0;
   bit snd_calm = 1'b0;
   int rcv_run  = 0;
   bit rcv_calm = 1'b0;

   wav_pcm16_stream_parser DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_byte_value    (req_byte_value),
      .req_end_of_file   (req_end_of_file),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_sample        (rsp_sample),
      .rsp_chunk_number  (rsp_chunk_number),
      .rsp_status        (rsp_status),
      .rsp_channel_count (rsp_channel_count),
      .rsp_rate_hz       (rsp_rate_hz),
      .rsp_sample_total  (rsp_sample_total),
      .rsp_final_chunk   (rsp_final_chunk),
      .rsp_last          (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The wait before the next transfer on one side. From time to time a
   // new run starts, and about one run in four has no idling at all.
   function automatic int draw_wait(ref int run_left, ref bit calm);
      if (run_left == 0) begin
         calm     = ($urandom_range(0, 3) == 0);
         run_left = $urandom_range(4, 40);
      end
      run_left--;
      return calm ? 0 : $urandom_range(0, 18);
   endfunction

   // Payload bytes lean toward the values that give extreme samples.
   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         3:       return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   // Appends one byte at the end of the file under construction.
   function automatic void add_byte(input logic [7:0] value);
      file_bytes.insert(file_bytes.size(), value);
   endfunction

   function automatic void put_u32(input logic [31:0] word);
      for (int i = 0; i < 4; i++) add_byte(word[8*i +: 8]);
   endfunction

   // A length word, a random body and, for an odd length, the pad byte.
   function automatic void put_sized_payload(input logic [31:0] len);
      put_u32(len);
      repeat (len) add_byte(rand_byte());
      if (len[0]) add_byte(rand_byte());
   endfunction

   // A format chunk. A clean one is a valid 16-byte PCM16 chunk. Otherwise
   // the length may be short, long or odd, and any field may be unsupported.
   function automatic void put_fmt_chunk(input bit clean);
      logic [127:0] img;
      logic [31:0]  len;
      int           r;
      r = $urandom_range(0, 9);
      if (clean || r < 6) len = wpsp_pkg::MIN_FMT_BYTES;
      else if (r == 6)    len = 32'd18;
      else if (r == 7)    len = 32'd17;
      else if (r == 8)    len = $urandom_range(0, 15);
      else                len = $urandom_range(19, 40);
      img[15:0] = (!clean && $urandom_range(0, 7) == 0) ?
                  16'($urandom) : wpsp_pkg::PCM_CODE;
      r = $urandom_range(0, 11);
      if (clean || r > 1) img[31:16] = 16'($urandom_range(1, 2));
      else if (r == 0)    img[31:16] = 16'd0;
      else                img[31:16] = 16'($urandom);
      img[63:32]   = (!clean && $urandom_range(0, 11) == 0) ? 32'd0 : 32'($urandom);
      img[111:64]  = {16'($urandom), 32'($urandom)};
      img[127:112] = (!clean && $urandom_range(0, 7) == 0) ?
                     16'($urandom) : wpsp_pkg::PCM_BITS;
      put_u32(wpsp_pkg::TAG_FMT);
      put_u32(len);
      for (int i = 0; i < len; i++) begin
         add_byte(i < 16 ? img[8*i +: 8] : rand_byte());
      end
      if (len[0]) add_byte(rand_byte());
   endfunction

   function automatic void build_random_file();
      int          pick, n_chunks, i, ending, cut;
      logic [31:0] tag;
      file_bytes.delete();
      pick = $urandom_range(0, 99);
      // Plain noise.
      if (pick < 8) begin
         repeat ($urandom_range(1, 70)) add_byte(8'($urandom));
         return;
      end
      put_u32(RIFF_WORD);
      put_u32($urandom);
      put_u32(WAVE_WORD);
      // A damaged RIFF or WAVE tag byte.
      if (pick < 18) begin
         i = $urandom_range(0, 7);
         if (i >= 4) i += 4;
         file_bytes[i] = file_bytes[i] ^ 8'($urandom_range(1, 255));
      end
      if ($urandom_range(0, 4) != 0) put_fmt_chunk(1'b0);
      n_chunks = $urandom_range(1, 4);
      for (i = 0; i < n_chunks; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            put_fmt_chunk(1'b0);
         end else if (pick < 8) begin
            put_u32(wpsp_pkg::TAG_DATA);
            put_sized_payload($urandom_range(0, 24));
         end else begin
            put_u32($urandom);
            put_sized_payload($urandom_range(0, 10));
         end
      end
      // How the file ends: after a whole chunk, cut anywhere, inside a chunk
      // that claims a huge length, or inside a chunk header.
      ending = $urandom_range(0, 9);
      if (ending == 7) begin
         cut = $urandom_range(1, file_bytes.size());
         while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end else if (ending == 8) begin
         put_u32($urandom_range(0, 1) ? wpsp_pkg::TAG_DATA : wpsp_pkg::TAG_FMT);
         put_u32($urandom | 32'h0100_0000);
         repeat ($urandom_range(0, 9)) add_byte(rand_byte());
      end else if (ending == 9) begin
         tag = $urandom_range(0, 1) ? wpsp_pkg::TAG_DATA : wpsp_pkg::TAG_FMT;
         cut = $urandom_range(1, 7);
         for (i = 0; i < cut; i++) add_byte(i < 4 ? tag[8*i +: 8] : rand_byte());
      end
   endfunction

   // Waits, then offers one byte and holds it until the transfer happens.
   // It is entered and left at a falling edge.
   task automatic send_byte(input logic [7:0] value, input logic last_byte);
      int gap;
      gap = draw_wait(snd_run, snd_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_byte_value  <= value;
      req_end_of_file <= last_byte;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(value, last_byte);
      @(negedge clock);
   endtask

   task automatic send_file();
      for (int i = 0; i < file_bytes.size(); i++) begin
         send_byte(file_bytes[i], i == file_bytes.size() - 1);
      end
   endtask

   // The sender holds off until every predicted result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   // Result side: stall at random, then take one result transfer and check it.
   initial begin
      int         stall;
      wave_result got;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = draw_wait(rcv_run, rcv_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.kind          = rsp_kind;
         got.sample        = rsp_sample;
         got.chunk_number  = rsp_chunk_number;
         got.status        = wpsp_pkg::status_type'(rsp_status);
         got.channel_count = rsp_channel_count;
         got.rate_hz       = rsp_rate_hz;
         got.sample_total  = rsp_sample_total;
         got.final_chunk   = rsp_final_chunk;
         got.last          = rsp_last;
         sb.check_result(got);
         @(negedge clock);
      end
   end

   // Main stimulus and the end of the run.
   initial begin
      int n, bytes_sent;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_byte_value  = '0;
      req_end_of_file = 1'b0;
      bytes_sent      = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A file of a single byte: too short and not RIFF.
      file_bytes.delete();
      add_byte(8'hFF);
      send_file();
      bytes_sent += file_bytes.size();

      // A file that ends on the second byte of a data chunk. That byte
      // yields the most negative sample and, right after it, a report
      // rejecting the file as too short.
      file_bytes.delete();
      put_u32(RIFF_WORD);
      put_u32(32'd0);
      put_u32(WAVE_WORD);
      put_u32(wpsp_pkg::TAG_DATA);
      put_u32(32'd2);
      add_byte(8'h00);
      add_byte(8'h80);
      send_file();
      bytes_sent += file_bytes.size();
      drain();

      // A long file with many data chunks, most of them empty. Samples from
      // the later chunks carry ever higher chunk indexes.
      file_bytes.delete();
      put_u32(RIFF_WORD);
      put_u32($urandom);
      put_u32(WAVE_WORD);
      put_fmt_chunk(1'b1);
      for (n = 0; n < 40; n++) begin
         put_u32(wpsp_pkg::TAG_DATA);
         put_sized_payload((n % 8 == 7 || n >= 36) ? $urandom_range(1, 5) : 0);
      end
      send_file();
      bytes_sent += file_bytes.size();
      drain();

      while (bytes_sent < 1350) begin
         build_random_file();
         bytes_sent += file_bytes.size();
         send_file();
         if ($urandom_range(0, 9) == 0) drain();
      end

      // Wait for the last results, with a bound, then for a short quiet time
      // in which any stray result would still be caught.
      req_valid <= 1'b0;
      for (n = 0; n < 5000 && sb.pending() != 0; n++) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0d expected results never arrived", sb.pending());
         sb.failures++;
      end
      if (sb.failures == 0) begin
         $display("tb_wav_pcm16_stream_parser OK");
      end else begin
         $display("tb_wav_pcm16_stream_parser NOT OK");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #8_000_000;
      $display("tb_wav_pcm16_stream_parser NOT OK");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/wpsp_pkg.sv
sv/wpsp_front.sv
sv/wpsp_queue.sv
sv/wpsp_back.sv
sv/wav_pcm16_stream_parser.sv
tb/tb_wav_pcm16_stream_parser.sv
